/* src/deadline_sorted_timer_queue_assert.svh */
// Assertion macros used by the timer queue datapath.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH

// Check a property outside reset.
`define DSTQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define DSTQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/dstq_pkg.sv */
// Types and constants of the deadline sorted timer queue.
package dstq_pkg;

    localparam int ID_W     = 5;
    localparam int DELAY_W  = 32;
    localparam int NOW_W    = 48;
    localparam int MAX_POPS = 32;

    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_SET    = 2'd0;
    localparam cmd_code_t CMD_CANCEL = 2'd1;
    localparam cmd_code_t CMD_CHECK  = 2'd2;

    typedef logic [1:0] kind_code_t;
    localparam kind_code_t KIND_SET_DONE    = 2'd0;
    localparam kind_code_t KIND_CANCEL_DONE = 2'd1;
    localparam kind_code_t KIND_EXPIRED     = 2'd2;
    localparam kind_code_t KIND_NONE        = 2'd3;

    typedef enum logic [2:0] {
        EMIT_OFF,
        EMIT_DONE,
        EMIT_EXP_MORE,
        EMIT_EXP_LAST,
        EMIT_NONE
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      rd_head;
        logic      advance;
        logic      unlink_cur;
        logic      place;
        logic      link_prev;
        logic      pop;
        emit_sel_t emit;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_code_t in_cmd;
        logic      in_id_ok;
        logic      in_hit;
        logic      cmd_set;
        logic      cur_null;
        logic      cur_is_id;
        logic      due;
        logic      later;
        logic      prev_null;
        logic      have_pops;
        logic      pop_cap;
        logic      out_free;
    } dp_status_t;

endpackage

/* src/dstq_cmd_if.sv */
// Command channel of the timer queue.
interface dstq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [4:0]  timer_id;
    logic [31:0] delay;
    logic [47:0] now;

    modport source (output valid, command, timer_id, delay, now, input ready);
    modport sink (input valid, command, timer_id, delay, now, output ready);
endinterface

/* src/dstq_res_if.sv */
// Result channel of the timer queue.
interface dstq_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [4:0] result_id;
    logic       was_queued;
    logic       last;

    modport source (output valid, kind, result_id, was_queued, last, input ready);
    modport sink (input valid, kind, result_id, was_queued, last, output ready);
endinterface

/* src/dstq_ram.sv */
// Generic single write port RAM with registered read.
module dstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/dstq_ctrl.sv */
// Sequencer for set, cancel and expiry walks of the timer queue.
module dstq_ctrl
    import dstq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNLINK,
        ST_INS_START,
        ST_INSERT,
        ST_LINK_PREV,
        ST_REPLY,
        ST_CHECK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   accept;

    assign in_ready = ready_reg;
    assign accept   = in_valid && ready_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.emit   = EMIT_OFF;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctl.accept  = 1'b1;
                    ctl.rd_head = 1'b1;
                    case (status.in_cmd)
                        CMD_SET:
                        begin
                            if (!status.in_id_ok)
                                state_next = ST_REPLY;
                            else if (status.in_hit)
                                state_next = ST_UNLINK;
                            else
                                state_next = ST_INSERT;
                        end
                        CMD_CANCEL:
                        begin
                            state_next = status.in_hit ? ST_UNLINK : ST_REPLY;
                        end
                        CMD_CHECK:
                        begin
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UNLINK:
            begin
                if (status.cur_null)
                begin
                    state_next = status.cmd_set ? ST_INS_START : ST_REPLY;
                end
                else if (status.cur_is_id)
                begin
                    ctl.unlink_cur = 1'b1;
                    state_next     = status.cmd_set ? ST_INS_START : ST_REPLY;
                end
                else
                begin
                    ctl.advance = 1'b1;
                end
            end
            ST_INS_START:
            begin
                ctl.rd_head = 1'b1;
                state_next  = ST_INSERT;
            end
            ST_INSERT:
            begin
                if (status.cur_null || status.later)
                begin
                    ctl.place  = 1'b1;
                    state_next = status.prev_null ? ST_REPLY : ST_LINK_PREV;
                end
                else
                begin
                    ctl.advance = 1'b1;
                end
            end
            ST_LINK_PREV:
            begin
                ctl.link_prev = 1'b1;
                state_next    = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (status.out_free)
                begin
                    ctl.emit   = EMIT_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (status.cur_null || !status.due || status.pop_cap)
                begin
                    if (status.out_free)
                    begin
                        ctl.emit   = status.have_pops ? EMIT_EXP_LAST : EMIT_NONE;
                        state_next = ST_IDLE;
                    end
                end
                else if (status.out_free || !status.have_pops)
                begin
                    // pop the head; the previous pop goes out now that more follow
                    ctl.pop = 1'b1;
                    if (status.have_pops)
                        ctl.emit = EMIT_EXP_MORE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

/* src/dstq_dp.sv */
// Datapath of the timer queue: list storage, walk registers and result register.
`include "deadline_sorted_timer_queue_assert.svh"

module dstq_dp
    import dstq_pkg::*;
#(
    parameter int NUM_TIMERS = 32,
    parameter int TIME_BITS  = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_cmd_t           ctl,
    output dp_status_t         status,
    input  logic [1:0]         command,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [DELAY_W-1:0] delay,
    input  logic [NOW_W-1:0]   now,
    dstq_res_if.source         res
);

    localparam int IDX_W  = $clog2(NUM_TIMERS);
    localparam int LINK_W = $clog2(NUM_TIMERS + 1);
    localparam int POP_W  = $clog2(MAX_POPS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_TIMERS);

    // walk and list state
    logic [LINK_W-1:0]     head_reg;
    logic [LINK_W-1:0]     cur_reg;
    logic [LINK_W-1:0]     prev_reg;
    logic [LINK_W-1:0]     last_id_reg;
    logic [POP_W-1:0]      pops_reg;
    logic [NUM_TIMERS-1:0] queued_reg;
    logic                  was_reg;

    // captured command
    cmd_code_t             cmd_reg;
    logic [ID_W-1:0]       id_reg;
    logic [TIME_BITS-1:0]  sum_reg;
    logic [TIME_BITS-1:0]  now_reg;

    // result register
    logic                  out_valid_reg;
    kind_code_t            kind_reg;
    logic [ID_W-1:0]       result_id_reg;
    logic                  was_queued_reg;
    logic                  last_reg;

    logic [NOW_W+TIME_BITS-1:0] now_wide;
    logic [TIME_BITS-1:0]       now_in;
    logic [TIME_BITS:0]         sum_full;
    logic [TIME_BITS-1:0]       sum_sat;
    logic [ID_W+IDX_W-1:0]      in_id_wide;
    logic [IDX_W-1:0]           in_idx;
    logic                       in_id_ok;
    logic [ID_W+IDX_W-1:0]      id_idx_wide;
    logic [IDX_W-1:0]           id_idx;
    logic [ID_W+LINK_W-1:0]     id_link_wide;
    logic [LINK_W-1:0]          id_link;
    logic [ID_W+LINK_W-1:0]     last_id_wide;
    logic [IDX_W-1:0]           cur_idx;
    logic [IDX_W-1:0]           prev_idx;
    logic                       prev_null;
    logic                       out_free;

    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [LINK_W-1:0]          link_rdata;
    logic [TIME_BITS-1:0]       dl_rdata;
    logic                       link_wr_en;
    logic [IDX_W-1:0]           link_wr_addr;
    logic [LINK_W-1:0]          link_wr_data;

    // saturating deadline
    assign now_wide = {{TIME_BITS{1'b0}}, now};
    assign now_in   = now_wide[TIME_BITS-1:0];
    assign sum_full = {1'b0, now_in} + (TIME_BITS + 1)'(delay);
    assign sum_sat  = sum_full[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_full[TIME_BITS-1:0];

    assign in_id_wide   = {{IDX_W{1'b0}}, timer_id};
    assign in_idx       = in_id_wide[IDX_W-1:0];
    assign in_id_ok     = (32'(timer_id) < 32'(NUM_TIMERS));
    assign id_idx_wide  = {{IDX_W{1'b0}}, id_reg};
    assign id_idx       = id_idx_wide[IDX_W-1:0];
    assign id_link_wide = {{LINK_W{1'b0}}, id_reg};
    assign id_link      = id_link_wide[LINK_W-1:0];
    assign last_id_wide = {{ID_W{1'b0}}, last_id_reg};
    assign cur_idx      = cur_reg[IDX_W-1:0];
    assign prev_idx     = prev_reg[IDX_W-1:0];
    assign prev_null    = (prev_reg == NULL_LINK);
    assign out_free     = !out_valid_reg || res.ready;

    // both stores share one read address: the head or the link just read
    assign rd_en   = ctl.rd_head || ctl.advance || ctl.pop;
    assign rd_addr = ctl.rd_head ? head_reg[IDX_W-1:0] : link_rdata[IDX_W-1:0];

    always_comb
    begin
        link_wr_en   = (ctl.unlink_cur && !prev_null) || ctl.place || ctl.link_prev;
        link_wr_addr = ctl.place ? id_idx : prev_idx;
        if (ctl.unlink_cur)
            link_wr_data = link_rdata;
        else if (ctl.place)
            link_wr_data = cur_reg;
        else
            link_wr_data = id_link;
    end

    dstq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_TIMERS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_rdata)
    );

    dstq_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_TIMERS)
    ) u_deadline_ram (
        .clk     (clk),
        .wr_en   (ctl.place),
        .wr_addr (id_idx),
        .wr_data (sum_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (dl_rdata)
    );

    always_comb
    begin
        status.in_cmd    = command;
        status.in_id_ok  = in_id_ok;
        status.in_hit    = in_id_ok && queued_reg[in_idx];
        status.cmd_set   = (cmd_reg == CMD_SET);
        status.cur_null  = (cur_reg == NULL_LINK);
        status.cur_is_id = (cur_reg == id_link);
        status.due       = (dl_rdata <= now_reg);
        status.later     = (dl_rdata > sum_reg);
        status.prev_null = prev_null;
        status.have_pops = (pops_reg != '0);
        status.pop_cap   = (pops_reg == POP_W'(MAX_POPS));
        status.out_free  = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_LINK;
            queued_reg    <= '0;
            pops_reg      <= '0;
            was_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                pops_reg <= '0;
                was_reg  <= 1'b0;
            end
            if (ctl.unlink_cur)
            begin
                if (prev_null)
                    head_reg <= link_rdata;
                queued_reg[id_idx] <= 1'b0;
                was_reg            <= 1'b1;
            end
            if (ctl.place)
            begin
                if (prev_null)
                    head_reg <= id_link;
                queued_reg[id_idx] <= 1'b1;
            end
            if (ctl.pop)
            begin
                head_reg            <= link_rdata;
                queued_reg[cur_idx] <= 1'b0;
                pops_reg            <= pops_reg + 1'b1;
            end
            if (ctl.emit != EMIT_OFF)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= command;
            id_reg  <= timer_id;
            sum_reg <= sum_sat;
            now_reg <= now_in;
        end
        if (ctl.rd_head)
        begin
            cur_reg  <= head_reg;
            prev_reg <= NULL_LINK;
        end
        else if (ctl.advance)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= link_rdata;
        end
        else if (ctl.pop)
        begin
            cur_reg     <= link_rdata;
            last_id_reg <= cur_reg;
        end
        case (ctl.emit)
            EMIT_DONE:
            begin
                kind_reg       <= (cmd_reg == CMD_SET) ? KIND_SET_DONE : KIND_CANCEL_DONE;
                result_id_reg  <= id_reg;
                was_queued_reg <= was_reg;
                last_reg       <= 1'b1;
            end
            EMIT_EXP_MORE, EMIT_EXP_LAST:
            begin
                kind_reg       <= KIND_EXPIRED;
                result_id_reg  <= last_id_wide[ID_W-1:0];
                was_queued_reg <= 1'b0;
                last_reg       <= (ctl.emit == EMIT_EXP_LAST);
            end
            EMIT_NONE:
            begin
                kind_reg       <= KIND_NONE;
                result_id_reg  <= '0;
                was_queued_reg <= 1'b0;
                last_reg       <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid      = out_valid_reg;
    assign res.kind       = kind_reg;
    assign res.result_id  = result_id_reg;
    assign res.was_queued = was_queued_reg;
    assign res.last       = last_reg;

    `DSTQ_ASSERT(a_emit_has_room, (ctl.emit != EMIT_OFF) |-> out_free, "result beat overwritten")
    `DSTQ_ASSERT_ALWAYS(a_head_in_range, head_reg <= NULL_LINK, "list head out of range")
    `DSTQ_ASSERT(a_pop_is_queued, ctl.pop |-> queued_reg[cur_idx], "popped timer not queued")
    `DSTQ_ASSERT(a_place_not_queued, ctl.place |-> !queued_reg[id_idx], "timer linked twice")

endmodule

/* src/deadline_sorted_timer_queue.sv */
// Top level of the deadline sorted timer queue.
//
// Usage: commands come in on cmd (set, cancel, check), results leave on res.
// A set stores deadline = now + delay, clamped at the top of the time range,
// behind every timer with an equal or earlier deadline; a set of a queued
// timer moves it. A cancel removes a timer. A check pops due timers in
// deadline order, at most MAX_POPS, one expiry beat each with last on the
// final one, or one none-expired beat.
// Storage: the list lives in two RAMs with registered read, walked one entry
// per cycle unless a check waits on res; a set that moves a queued timer
// walks the list twice, once to unlink it and once to place it.
// One command is worked at a time; cmd.ready is high only between commands.
// The last result sits in an output register, so a new command is taken
// while it waits. When res stalls, a check walk holds until the beat is taken.
// Reset empties the list at once; no clearing pass is run.
module deadline_sorted_timer_queue
    import dstq_pkg::*;
#(
    parameter int NUM_TIMERS = 32,
    parameter int TIME_BITS  = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    dstq_cmd_if.sink   cmd,
    dstq_res_if.source res
);

    ctl_cmd_t   ctl;
    dp_status_t status;

    dstq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .status   (status),
        .ctl      (ctl)
    );

    dstq_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .status   (status),
        .command  (cmd.command),
        .timer_id (cmd.timer_id),
        .delay    (cmd.delay),
        .now      (cmd.now),
        .res      (res)
    );

endmodule
